// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rgbrc_pkg.sv =====
// shared constants, codes and types of the rgb row convolution
package rgbrc_pkg;

  localparam int PIX_W        = 16;
  localparam int TAP_W        = 17;
  localparam int TAP_FRAC     = 16;
  localparam int OCOL_W       = 11;
  localparam int ROW_WIDTH_W  = 12;
  localparam int RADIUS_W     = 4;
  localparam int TAP_IDX_W    = 5;
  localparam int CFG_DATA_W   = 17;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_RESULTS  = 16;

  localparam int DEF_MAX_WIDTH    = 2048;
  localparam int DEF_MAX_RADIUS   = 15;
  localparam int DEF_CHANNEL_BITS = 16;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = ROW_WIDTH_W'(2048);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH = 2'd0,
    CFG_RADIUS    = 2'd1,
    CFG_TAP_INDEX = 2'd2,
    CFG_TAP_VALUE = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } st_e;

endpackage

// ===== rtl/core/rgbrc_if.sv =====
// pixel and result channel interfaces
interface rgbrc_pix_if import rgbrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rgbrc_res_if import rgbrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  red_out;
  logic [PIX_W-1:0]  green_out;
  logic [PIX_W-1:0]  blue_out;
  logic [OCOL_W-1:0] out_column;
  logic              row_done;
  logic              run_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output out_column, output row_done, output run_end, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input out_column, input row_done, input run_end, output ready);
endinterface

// ===== rtl/core/rgbrc_ram.sv =====
// generic single-clock ram, one write port, one registered read port
module rgbrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rgb_row_convolution_symmetric_edges.sv =====
// a taken pixel is stored in the row memory; each output column then reads the row
// memory once per tap (2R+1 reads), drains the read, multiply and accumulate stages
// and waits for a free output register; a pixel is taken only while idle, so no new pixel
// is accepted until its columns are out, and a row end flush yields up to 16 columns
// reset: row width 2048, radius 0, taps read as zero, input column 0;
// the row memory is not cleared and is read only where the current row wrote it
module rgb_row_convolution_symmetric_edges import rgbrc_pkg::*; #(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS   = DEF_MAX_RADIUS,
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rgbrc_pix_if.sink             pix_i,
  rgbrc_res_if.source           res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int RW        = $clog2(MAX_RADIUS + 1);
  localparam int TAP_COUNT = 2 * MAX_RADIUS + 1;
  localparam int TAP_AW    = $clog2(TAP_COUNT);
  localparam int M         = (CW + 1 > RW) ? CW + 1 : RW;
  localparam int SW        = M + 2;
  localparam int WCW       = (ROW_WIDTH_W > CW + 1) ? ROW_WIDTH_W : CW + 1;
  localparam int RCW       = (RADIUS_W > RW) ? RADIUS_W : RW;
  localparam int TW        = ((TAP_IDX_W > TAP_AW) ? TAP_IDX_W : TAP_AW) + 1;
  localparam int PROD_W    = PIX_W + TAP_W;
  localparam int ACC_W     = PROD_W + TAP_AW;
  localparam int SH_W      = ACC_W + 1 - TAP_FRAC;
  localparam int CMP_W     = ((SH_W > CHANNEL_BITS) ? SH_W : CHANNEL_BITS) + 1;
  localparam int ROW_W     = 3 * PIX_W;

  localparam logic [PIX_W-1:0] PIX_MASK =
    (CHANNEL_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((64'd1 << CHANNEL_BITS) - 64'd1);
  localparam logic [CMP_W-1:0] CHAN_MAX = CMP_W'((64'd1 << CHANNEL_BITS) - 64'd1);
  localparam logic [ACC_W:0]   RND      = (ACC_W + 1)'(64'd1 << (TAP_FRAC - 1));
  localparam logic signed [SW-1:0] ONE_S = SW'(1);

  // configuration
  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic [RADIUS_W-1:0]    radius_q;
  logic [TAP_IDX_W-1:0]   tap_idx_q;
  logic [TAP_COUNT-1:0]   tap_written_q;
  logic                   tap_we;
  logic [TAP_AW-1:0]      tap_waddr;

  logic [WCW-1:0] rw_ext;
  logic [CW:0]    w_eff;
  logic [RCW-1:0] rad_ext;
  logic [RW-1:0]  r_eff;

  // sequencer
  st_e                    st_q, st_d;
  logic [CW-1:0]          in_col_q, in_col_d;
  logic [CW-1:0]          col_q, col_d;
  logic [CW-1:0]          last_q, last_d;
  logic signed [SW-1:0]   x_q, x_d;
  logic [TAP_AW-1:0]      j_q, j_d;
  logic [TAP_AW-1:0]      j_end;
  logic                   issue, acc_clr, load_res;

  logic          pix_fire, res_free;
  logic [M-1:0]  cur_m, r_m, wm1_m, first_m, lim_m, last_m;
  logic          flush, has_col;

  // mirror
  logic signed [SW-1:0] w_s, mir_a, mir_b;
  logic [CW-1:0]        src_addr;

  // datapath
  logic [ROW_W-1:0]  row_rd;
  logic [TAP_W-1:0]  tap_rd;
  logic              v1_q, v2_q, tap_ok_q;
  logic [PIX_W-1:0]  pix_rd [3];
  logic [TAP_W-1:0]  tap_use;
  logic [PROD_W-1:0] prod_q [3];
  logic [ACC_W-1:0]  acc_q [3];
  logic [ACC_W:0]    rsum [3];
  logic [CMP_W-1:0]  rsh [3];
  logic [PIX_W-1:0]  rout [3];

  // output register
  logic              res_vld_q;
  logic [PIX_W-1:0]  res_red_q, res_green_q, res_blue_q;
  logic [OCOL_W-1:0] res_col_q;
  logic              res_done_q, res_end_q;

  // effective width and radius
  always_comb begin
    rw_ext  = WCW'(row_width_q);
    rad_ext = RCW'(radius_q);
    if (rw_ext == '0) begin
      w_eff = (CW + 1)'(1);
    end else if (rw_ext > WCW'(MAX_WIDTH)) begin
      w_eff = (CW + 1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW + 1)'(rw_ext);
    end
    if (rad_ext > RCW'(MAX_RADIUS)) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(rad_ext);
    end
  end

  // configuration writes
  assign tap_waddr = TAP_AW'(tap_idx_q);
  assign tap_we    = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == CFG_TAP_VALUE)
                     && (TW'(tap_idx_q) < TW'(TAP_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q   <= ROW_WIDTH_RST;
      radius_q      <= '0;
      tap_idx_q     <= '0;
      tap_written_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_ROW_WIDTH: row_width_q <= cfg_data_i[ROW_WIDTH_W-1:0];
        CFG_RADIUS:    radius_q    <= cfg_data_i[RADIUS_W-1:0];
        CFG_TAP_INDEX: tap_idx_q   <= cfg_data_i[TAP_IDX_W-1:0];
        CFG_TAP_VALUE: begin
          if (tap_we) begin
            tap_written_q[tap_waddr] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  rgbrc_ram #(.WIDTH(TAP_W), .DEPTH(TAP_COUNT)) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (tap_waddr),
    .wdata_i (cfg_data_i[TAP_W-1:0]),
    .re_i    (issue),
    .raddr_i (j_q),
    .rdata_o (tap_rd)
  );

  // column range for the incoming pixel
  assign pix_fire = pix_i.valid && pix_i.ready;
  assign res_free = !res_vld_q || res_o.ready;
  assign pix_i.ready = (st_q == ST_IDLE);

  always_comb begin
    cur_m   = M'(in_col_q);
    r_m     = M'(r_eff);
    wm1_m   = M'(w_eff) - M'(1);
    flush   = (cur_m >= wm1_m);
    has_col = (cur_m >= r_m);
    first_m = has_col ? (cur_m - r_m) : '0;
    lim_m   = first_m + M'(MAX_RESULTS - 1);
    if (flush) begin
      last_m = (lim_m < wm1_m) ? lim_m : wm1_m;
    end else begin
      last_m = first_m;
    end
  end

  assign j_end = TAP_AW'({r_eff, 1'b0});

  always_comb begin
    st_d     = st_q;
    in_col_d = in_col_q;
    col_d    = col_q;
    last_d   = last_q;
    x_d      = x_q;
    j_d      = j_q;
    issue    = 1'b0;
    acc_clr  = 1'b0;
    load_res = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (pix_fire) begin
          in_col_d = flush ? '0 : (in_col_q + CW'(1));
          // a row end whose first column lies past a shrunk width emits nothing
          if ((flush && (first_m <= wm1_m)) || (!flush && has_col)) begin
            col_d   = CW'(first_m);
            last_d  = CW'(last_m);
            j_d     = '0;
            acc_clr = 1'b1;
            st_d    = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        x_d   = x_q - ONE_S;
        j_d   = j_q + TAP_AW'(1);
        if (j_q == j_end) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q) begin
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_free) begin
          load_res = 1'b1;
          if (col_q == last_q) begin
            st_d = ST_IDLE;
          end else begin
            col_d   = col_q + CW'(1);
            j_d     = '0;
            acc_clr = 1'b1;
            st_d    = ST_RUN;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
    if (acc_clr) begin
      x_d = SW'(col_d) + SW'(r_eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      in_col_q <= '0;
      col_q    <= '0;
      last_q   <= '0;
      x_q      <= '0;
      j_q      <= '0;
    end else begin
      st_q     <= st_d;
      in_col_q <= in_col_d;
      col_q    <= col_d;
      last_q   <= last_d;
      x_q      <= x_d;
      j_q      <= j_d;
    end
  end

  // reflect about the outer edge of the edge pixel, so it repeats, then clamp into the row
  always_comb begin
    w_s = SW'(w_eff);
    if (x_q[SW-1]) begin
      mir_a = -x_q - ONE_S;
    end else if (x_q >= w_s) begin
      mir_a = w_s + w_s - x_q - ONE_S;
    end else begin
      mir_a = x_q;
    end
    if (mir_a > w_s - ONE_S) begin
      mir_b = w_s - ONE_S;
    end else if (mir_a[SW-1]) begin
      mir_b = '0;
    end else begin
      mir_b = mir_a;
    end
    src_addr = mir_b[CW-1:0];
  end

  rgbrc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_WIDTH)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (pix_fire),
    .waddr_i (in_col_q),
    .wdata_i ({pix_i.red_in & PIX_MASK, pix_i.green_in & PIX_MASK,
               pix_i.blue_in & PIX_MASK}),
    .re_i    (issue),
    .raddr_i (src_addr),
    .rdata_o (row_rd)
  );

  // read, multiply, accumulate
  assign pix_rd[0] = row_rd[3*PIX_W-1:2*PIX_W];
  assign pix_rd[1] = row_rd[2*PIX_W-1:PIX_W];
  assign pix_rd[2] = row_rd[PIX_W-1:0];
  assign tap_use   = tap_ok_q ? tap_rd : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      tap_ok_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (issue) begin
        tap_ok_q <= tap_written_q[j_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (v1_q) begin
        prod_q[ch] <= {{TAP_W{1'b0}}, pix_rd[ch]} * {{PIX_W{1'b0}}, tap_use};
      end
      if (acc_clr) begin
        acc_q[ch] <= '0;
      end else if (v2_q) begin
        acc_q[ch] <= acc_q[ch] + ACC_W'(prod_q[ch]);
      end
    end
  end

  // round half up and saturate
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      rsum[ch] = (ACC_W + 1)'(acc_q[ch]) + RND;
      rsh[ch]  = CMP_W'(rsum[ch][ACC_W:TAP_FRAC]);
      rout[ch] = (rsh[ch] > CHAN_MAX) ? CHAN_MAX[PIX_W-1:0] : rsh[ch][PIX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (load_res) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_red_q   <= rout[0];
      res_green_q <= rout[1];
      res_blue_q  <= rout[2];
      res_col_q   <= OCOL_W'(col_q);
      res_done_q  <= ((CW + 1)'(col_q) == w_eff - (CW + 1)'(1));
      res_end_q   <= (col_q == last_q);
    end
  end

  assign res_o.valid      = res_vld_q;
  assign res_o.red_out    = res_red_q;
  assign res_o.green_out  = res_green_q;
  assign res_o.blue_out   = res_blue_q;
  assign res_o.out_column = res_col_q;
  assign res_o.row_done   = res_done_q;
  assign res_o.run_end    = res_end_q;

endmodule

// ===== rtl/core/rgbrc_chk.sv =====
// port-level checker for the rgb row convolution, bound to the top level
`include "assert_macros.svh"

module rgbrc_chk import rgbrc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              pix_ready_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [PIX_W-1:0]  red_i,
  input logic [PIX_W-1:0]  green_i,
  input logic [PIX_W-1:0]  blue_i,
  input logic [OCOL_W-1:0] column_i,
  input logic              row_done_i,
  input logic              run_end_i
);

  logic res_beat;
  assign res_beat = res_valid_i && res_ready_i;

  // a stalled result beat stays and holds its payload
  `ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable({red_i, green_i, blue_i, column_i, row_done_i, run_end_i}), "result beat changed while stalled")

  // the last column of a row always closes its run
  `ASSERT_IMPLIES(a_row_done_ends_run, res_valid_i && row_done_i, run_end_i, "row end without run end")

  // no pixel is taken while a run still has columns to deliver
  `ASSERT_IMPLIES(a_busy_in_run, res_beat && !run_end_i, !pix_ready_i, "pixel ready inside an open run")

endmodule

bind rgb_row_convolution_symmetric_edges rgbrc_chk u_rgbrc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_ready_i (pix_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .red_i       (res_o.red_out),
  .green_i     (res_o.green_out),
  .blue_i      (res_o.blue_out),
  .column_i    (res_o.out_column),
  .row_done_i  (res_o.row_done),
  .run_end_i   (res_o.run_end)
);

// ===== bench/rgbrc_checker.sv =====
// checker for the rgb row convolution: predicts filtered columns from pixel and register beats
`timescale 1ns / 1ps
module rgbrc_checker import rgbrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rgbrc_pix_if                  pix_i,
  rgbrc_res_if                  res_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           pending_o,
  output int unsigned           columns_o,
  output int unsigned           errors_o
);
  localparam int LINE_MAX = DEF_MAX_WIDTH;
  localparam int TAPS     = 2 * DEF_MAX_RADIUS + 1;
  localparam logic [63:0] CHAN_MAX = (64'd1 << DEF_CHANNEL_BITS) - 64'd1;
  localparam logic [63:0] HALF_LSB = 64'd1 << (TAP_FRAC - 1);

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t              pix;
    logic [OCOL_W-1:0] column;
    logic              row_done;
    logic              run_end;
  } blurred_t;

  rgb_t                   line_buf [LINE_MAX];
  logic [TAP_W-1:0]       kernel [TAPS];
  logic [ROW_WIDTH_W-1:0] width_q;
  logic [RADIUS_W-1:0]    radius_q;
  logic [TAP_IDX_W-1:0]   tap_sel_q;
  int                     col_q;
  blurred_t               blurred_q [$];
  int unsigned            seen;
  int unsigned            bad;

  // mirror about the outer edge of the edge pixel, so it repeats, then clamp for rows narrower than the radius
  function automatic int reflect(int x, int w);
    int s;
    s = x;
    if (x < 0) begin
      s = -x - 1;
    end else if (x >= w) begin
      s = 2 * w - x - 1;
    end
    if (s > w - 1) s = w - 1;
    if (s < 0) s = 0;
    return s;
  endfunction

  function automatic logic [PIX_W-1:0] round_sat(logic [63:0] acc);
    logic [63:0] v;
    v = (acc + HALF_LSB) >> TAP_FRAC;
    return (v > CHAN_MAX) ? CHAN_MAX[PIX_W-1:0] : v[PIX_W-1:0];
  endfunction

  function automatic blurred_t blur_at(int col, int w, int r, bit last);
    logic [63:0] acc_r;
    logic [63:0] acc_g;
    logic [63:0] acc_b;
    int          k;
    int          src;
    blurred_t    res;
    acc_r = '0;
    acc_g = '0;
    acc_b = '0;
    for (k = -r; k <= r; k++) begin
      src = reflect(col - k, w);
      acc_r += 64'(line_buf[src].red) * 64'(kernel[k + r]);
      acc_g += 64'(line_buf[src].green) * 64'(kernel[k + r]);
      acc_b += 64'(line_buf[src].blue) * 64'(kernel[k + r]);
    end
    res.pix.red   = round_sat(acc_r);
    res.pix.green = round_sat(acc_g);
    res.pix.blue  = round_sat(acc_b);
    res.column    = OCOL_W'(col);
    res.row_done  = (col == w - 1);
    res.run_end   = last;
    return res;
  endfunction

  function automatic void take_pixel(rgb_t px);
    int w;
    int r;
    int cur;
    int first;
    int lastc;
    int c;
    if (width_q == 0) begin
      w = 1;
    end else if (width_q > LINE_MAX) begin
      w = LINE_MAX;
    end else begin
      w = int'(width_q);
    end
    r = (radius_q > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : int'(radius_q);
    cur = col_q;
    if (cur < LINE_MAX) line_buf[cur] = px;
    if (cur >= w - 1) begin
      first = (cur - r < 0) ? 0 : cur - r;
      lastc = w - 1;
      if (lastc - first + 1 > MAX_RESULTS) lastc = first + MAX_RESULTS - 1;
      for (c = first; c <= lastc; c++) blurred_q.push_back(blur_at(c, w, r, c == lastc));
      col_q = 0;
    end else begin
      if (cur - r >= 0) blurred_q.push_back(blur_at(cur - r, w, r, 1'b1));
      col_q = cur + 1;
    end
  endfunction

  function automatic void match_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      bad++;
    end
  endfunction

  function automatic void check_beat();
    blurred_t want;
    if (blurred_q.size() == 0) begin
      $error("result beat for column %0d with nothing expected", res_i.out_column);
      bad++;
    end else begin
      want = blurred_q.pop_front();
      match_field("red_out", want.pix.red, res_i.red_out);
      match_field("green_out", want.pix.green, res_i.green_out);
      match_field("blue_out", want.pix.blue, res_i.blue_out);
      match_field("out_column", want.column, res_i.out_column);
      match_field("row_done", want.row_done, res_i.row_done);
      match_field("run_end", want.run_end, res_i.run_end);
    end
    seen++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   = ROW_WIDTH_RST;
      radius_q  = '0;
      tap_sel_q = '0;
      foreach (kernel[i]) kernel[i] = '0;
      col_q     = 0;
      blurred_q.delete();
      seen      = 0;
      bad       = 0;
      pending_o <= 0;
      columns_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_ROW_WIDTH: width_q = cfg_data_i[ROW_WIDTH_W-1:0];
          CFG_RADIUS:    radius_q = cfg_data_i[RADIUS_W-1:0];
          CFG_TAP_INDEX: tap_sel_q = cfg_data_i[TAP_IDX_W-1:0];
          CFG_TAP_VALUE: begin
            if (tap_sel_q < TAPS) kernel[tap_sel_q] = cfg_data_i[TAP_W-1:0];
          end
          default: ;
        endcase
      end
      if (pix_i.valid && pix_i.ready) begin
        take_pixel(rgb_t'{pix_i.red_in, pix_i.green_in, pix_i.blue_in});
      end
      if (res_i.valid && res_i.ready) check_beat();
      pending_o <= blurred_q.size();
      columns_o <= seen;
      errors_o  <= bad;
    end
  end

endmodule

// ===== bench/tb_rgb_row_convolution_symmetric_edges.sv =====
// testbench top for the rgb row convolution: pixel stimulus, register setup, back-pressure, verdict
`timescale 1ns / 1ps
module tb_rgb_row_convolution_symmetric_edges;
  import rgbrc_pkg::*;

  localparam int PIXELS_TOTAL  = 280;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 2 * DEF_MAX_RADIUS + 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 120;
  localparam logic [CFG_DATA_W-1:0] TAP_ONE  = 17'h10000;
  localparam logic [CFG_DATA_W-1:0] TAP_FULL = 17'h1FFFF;

  typedef enum int {
    KERNEL_RANDOM,
    KERNEL_UNITY,
    KERNEL_FULL
  } kernel_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           pending;
  int unsigned           columns;
  int unsigned           mismatches;
  int unsigned           beats_sent = 0;
  int unsigned           reg_writes = 0;
  int unsigned           phases = 0;
  int unsigned           idle_cycles = 0;
  bit                    steady = 1'b0;
  bit                    hold_done = 1'b0;

  rgbrc_pix_if pix_if ();
  rgbrc_res_if res_if ();

  rgb_row_convolution_symmetric_edges dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pix_i      (pix_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  rgbrc_checker u_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pix_i      (pix_if),
    .res_i      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .columns_o  (columns),
    .errors_o   (mismatches)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pause_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [PIX_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  // result side: random stalls, a steady mode and one long hold-off while pixels keep coming
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && beats_sent >= HOLD_AFTER && pix_if.valid) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (steady || $urandom_range(0, 99) < 65) begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        res_if.ready <= 1'b0;
        repeat (pause_len()) @(posedge clk);
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic set_filter(int unsigned width, int unsigned rad, kernel_e style);
    int unsigned           i;
    logic [CFG_DATA_W-1:0] tap;
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(width));
    write_reg(CFG_RADIUS, CFG_DATA_W'(rad));
    for (i = 0; i <= 2 * rad; i++) begin
      case (style)
        KERNEL_UNITY: tap = (i == rad) ? TAP_ONE : '0;
        KERNEL_FULL:  tap = TAP_FULL;
        default: begin
          case ($urandom_range(0, 9))
            0:       tap = '0;
            1:       tap = TAP_ONE;
            2:       tap = TAP_FULL;
            default: tap = CFG_DATA_W'($urandom_range(0, 2 * 65536 / (2 * rad + 1)));
          endcase
        end
      endcase
      write_reg(CFG_TAP_INDEX, CFG_DATA_W'(i));
      write_reg(CFG_TAP_VALUE, tap);
    end
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] red, logic [PIX_W-1:0] green,
                            logic [PIX_W-1:0] blue);
    int unsigned gap;
    gap = steady ? 0 : (($urandom_range(0, 99) < 55) ? 0 : pause_len());
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid    <= 1'b1;
    pix_if.red_in   <= red;
    pix_if.green_in <= green;
    pix_if.blue_in  <= blue;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_random();
    send_pixel(pick_level(), pick_level(), pick_level());
  endtask

  // stop offering, wait for every expected column, then let a pixel with no column settle
  task automatic drain();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned w;
    int unsigned r;
    int unsigned rows;
    kernel_e     style;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_ROW_WIDTH;
    cfg_data        <= '0;
    pix_if.valid    <= 1'b0;
    pix_if.red_in   <= '0;
    pix_if.green_in <= '0;
    pix_if.blue_in  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single pixel rows through a unity kernel
    set_filter(0, 0, KERNEL_UNITY);
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hAAAA, 16'h5555, 16'h8001);
    drain();

    // widest kernel on a one pixel row, full taps, and a tap write past the table
    set_filter(0, 15, KERNEL_FULL);
    write_reg(CFG_TAP_INDEX, CFG_DATA_W'(31));
    write_reg(CFG_TAP_VALUE, '0);
    send_pixel(16'hFFFF, 16'h0001, 16'h7FFF);
    send_pixel(16'h0001, 16'h0000, 16'h0100);
    drain();

    // row narrower than the radius
    set_filter(3, 5, KERNEL_RANDOM);
    repeat (3) send_random();
    drain();

    // radius and width changed part way through a row
    set_filter(6, 2, KERNEL_RANDOM);
    repeat (3) send_random();
    drain();
    write_reg(CFG_RADIUS, CFG_DATA_W'(1));
    send_random();
    drain();
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(2));
    send_random();
    drain();

    // width register saturated to the row store size, then cut short
    set_filter(4095, 3, KERNEL_RANDOM);
    repeat (8) send_random();
    drain();
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(8));
    send_random();
    drain();

    while (beats_sent < PIXELS_TOTAL) begin
      phases++;
      steady = (phases % 5 == 2);
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 2);
        1, 2:    w = $urandom_range(17, 48);
        default: w = $urandom_range(3, 16);
      endcase
      r = $urandom_range(0, 15);
      case ($urandom_range(0, 9))
        0:       style = KERNEL_UNITY;
        1:       style = KERNEL_FULL;
        default: style = KERNEL_RANDOM;
      endcase
      set_filter(w, r, style);
      rows = $urandom_range(1, 3);
      repeat (rows) repeat ((w == 0) ? 1 : w) send_random();
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6)) send_random();
        drain();
        if ($urandom_range(0, 1) == 0) begin
          write_reg(CFG_RADIUS, CFG_DATA_W'($urandom_range(0, 15)));
        end else begin
          write_reg(CFG_ROW_WIDTH, CFG_DATA_W'($urandom_range(1, 12)));
        end
        repeat ($urandom_range(1, 20)) send_random();
      end
      drain();
    end
    steady = 1'b0;

    $display("sent %0d pixel beats and %0d register writes over %0d random settings",
             beats_sent, reg_writes, phases);
    $display("checked %0d filtered columns, radius 0 to 15, row widths 1 to 2048", columns);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
